@@ rtl/shell_command_tokenizer_macros.svh @@
// Assertion macros shared by the tokenizer checker.
`ifndef SHELL_COMMAND_TOKENIZER_MACROS_SVH
`define SHELL_COMMAND_TOKENIZER_MACROS_SVH

// Same-cycle implication, sampled on clk_i, off while rst_ni is low.
`define SCT_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk_i, off while rst_ni is low.
`define SCT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/sct_pkg.sv @@
// Types, character codes and helper functions of the shell command tokenizer.
package sct_pkg;

  localparam int unsigned MaxResults = 4;
  localparam int unsigned CntW       = $clog2(MaxResults + 1);
  localparam int unsigned IdxW       = $clog2(MaxResults);

  typedef enum logic [3:0] {
    K_CHAR    = 4'd0,
    K_WEND    = 4'd1,
    K_PIPE    = 4'd2,
    K_OR      = 4'd3,
    K_AND     = 4'd4,
    K_OUT     = 4'd5,
    K_APPEND  = 4'd6,
    K_IN      = 4'd7,
    K_HEREDOC = 4'd8,
    K_LPAREN  = 4'd9,
    K_RPAREN  = 4'd10,
    K_EOL     = 4'd11
  } kind_e;

  typedef enum logic [2:0] {
    PEND_NONE = 3'd0,
    PEND_PIPE = 3'd1,
    PEND_AMP  = 3'd2,
    PEND_GT   = 3'd3,
    PEND_LT   = 3'd4
  } pend_e;

  localparam logic [7:0] ChPipe  = 8'h7C;
  localparam logic [7:0] ChAmp   = 8'h26;
  localparam logic [7:0] ChGt    = 8'h3E;
  localparam logic [7:0] ChLt    = 8'h3C;
  localparam logic [7:0] ChLpar  = 8'h28;
  localparam logic [7:0] ChRpar  = 8'h29;
  localparam logic [7:0] ChSpace = 8'h20;
  localparam logic [7:0] ChNul   = 8'h00;
  localparam logic [7:0] ChTab   = 8'h09;
  localparam logic [7:0] ChCr    = 8'h0D;

  typedef struct packed {
    kind_e      kind;
    logic [7:0] ch;
  } tok_t;

  typedef struct packed {
    logic [CntW-1:0]             num;
    tok_t [MaxResults-1:0]       tok;
  } burst_t;

  function automatic pend_e op_code(logic [7:0] c);
    pend_e p;
    case (c)
      ChPipe:  p = PEND_PIPE;
      ChAmp:   p = PEND_AMP;
      ChGt:    p = PEND_GT;
      ChLt:    p = PEND_LT;
      default: p = PEND_NONE;
    endcase
    return p;
  endfunction

  function automatic logic is_space(logic [7:0] c);
    return (c == ChNul) || (c == ChSpace) || ((c >= ChTab) && (c <= ChCr));
  endfunction

  // Single form exists for | > < only; a lone & and unknown codes give nothing.
  function automatic logic has_single(pend_e p);
    return (p == PEND_PIPE) || (p == PEND_GT) || (p == PEND_LT);
  endfunction

  function automatic kind_e single_kind(pend_e p);
    kind_e k;
    case (p)
      PEND_GT: k = K_OUT;
      PEND_LT: k = K_IN;
      default: k = K_PIPE;
    endcase
    return k;
  endfunction

  function automatic kind_e double_kind(pend_e p);
    kind_e k;
    case (p)
      PEND_AMP: k = K_AND;
      PEND_GT:  k = K_APPEND;
      PEND_LT:  k = K_HEREDOC;
      default:  k = K_OR;
    endcase
    return k;
  endfunction

  // Append one token to a burst; drop it once the burst is full.
  function automatic burst_t push(burst_t b, kind_e k, logic [7:0] c);
    burst_t r;
    r = b;
    if (r.num < CntW'(MaxResults)) begin
      r.tok[r.num[IdxW-1:0]].kind = k;
      r.tok[r.num[IdxW-1:0]].ch   = (k == K_CHAR) ? c : 8'd0;
      r.num = r.num + CntW'(1);
    end
    return r;
  endfunction

endpackage

@@ rtl/sct_decode.sv @@
// Byte classifier: holds lexer state and builds the token burst of one item.
module sct_decode
  import sct_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       acc_i,
  input  logic [7:0] byte_i,
  input  logic       fin_i,
  output burst_t     burst_o
);

  pend_e  pend_q, pend_d;
  logic   word_q, word_d;
  burst_t b;
  pend_e  pc;
  logic   consumed;

  always_comb begin
    b        = '0;
    pend_d   = pend_q;
    word_d   = word_q;
    consumed = 1'b0;
    pc       = op_code(byte_i);

    // Resolve a waiting operator: double form eats this byte.
    if (pend_q != PEND_NONE) begin
      if (pc == pend_q) begin
        b        = push(b, double_kind(pend_q), 8'd0);
        consumed = 1'b1;
      end else if (has_single(pend_q)) begin
        b = push(b, single_kind(pend_q), 8'd0);
      end
      pend_d = PEND_NONE;
    end

    if (!consumed) begin
      if (is_space(byte_i)) begin
        if (word_d) b = push(b, K_WEND, 8'd0);
        word_d = 1'b0;
      end else if (pc != PEND_NONE) begin
        if (word_d) b = push(b, K_WEND, 8'd0);
        word_d = 1'b0;
        pend_d = pc;
      end else if (byte_i == ChLpar) begin
        if (word_d) b = push(b, K_WEND, 8'd0);
        word_d = 1'b0;
        b      = push(b, K_LPAREN, 8'd0);
      end else if (byte_i == ChRpar) begin
        if (word_d) b = push(b, K_WEND, 8'd0);
        word_d = 1'b0;
        b      = push(b, K_RPAREN, 8'd0);
      end else begin
        b      = push(b, K_CHAR, byte_i);
        word_d = 1'b1;
      end
    end

    // Final byte: flush operator, close word, mark end of line.
    if (fin_i) begin
      if (has_single(pend_d)) b = push(b, single_kind(pend_d), 8'd0);
      if (word_d) b = push(b, K_WEND, 8'd0);
      b      = push(b, K_EOL, 8'd0);
      pend_d = PEND_NONE;
      word_d = 1'b0;
    end
  end

  assign burst_o = b;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= PEND_NONE;
      word_q <= 1'b0;
    end else if (acc_i) begin
      pend_q <= pend_d;
      word_q <= word_d;
    end
  end

endmodule

@@ rtl/sct_burst.sv @@
// Result register: holds one item's tokens and drains them one per cycle while out_ready_i is high.
module sct_burst
  import sct_pkg::*;
(
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   in_valid_i,
  output logic   in_ready_o,
  input  burst_t burst_i,
  output logic   out_valid_o,
  input  logic   out_ready_i,
  output tok_t   tok_o,
  output logic   last_o
);

  tok_t [MaxResults-1:0] tok_q;
  logic [CntW-1:0]       rem_q;
  logic [IdxW-1:0]       idx_q;
  logic                  load;
  logic                  pop;

  assign out_valid_o = (rem_q != '0);
  assign pop         = out_valid_o && out_ready_i;
  // Take a new item once the held burst is empty or its final token leaves now.
  assign in_ready_o  = (rem_q == '0) || ((rem_q == CntW'(1)) && out_ready_i);
  assign load        = in_valid_i && in_ready_o;
  assign tok_o       = tok_q[idx_q];
  assign last_o      = (rem_q == CntW'(1));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rem_q <= '0;
      idx_q <= '0;
    end else if (load) begin
      rem_q <= burst_i.num;
      idx_q <= '0;
    end else if (pop) begin
      rem_q <= rem_q - CntW'(1);
      idx_q <= idx_q + IdxW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      tok_q <= burst_i.tok;
    end
  end

endmodule

@@ rtl/shell_command_tokenizer.sv @@
// Shell command tokenizer top level. One byte of a command line enters per item;
// the byte is classified against the current lexer state (waiting operator, open
// word) and the item's tokens, zero to four of them, are loaded into a result
// register in the same cycle. That register drives the output port and hands out
// one token per cycle while out_ready_i is high, with last set on the final token
// of the item. Plain word text streams at one byte per clock while out_ready_i is
// high; an item that yields more tokens (up to four, e.g. a closing byte that
// flushes a pending operator and an open word and adds the end-of-line token)
// holds the input until the single output port has drained the result register.
// A new item is taken in the same cycle the previous burst hands out its last
// token. Waiting | & > < decide their single or double form on the next byte;
// a lone & gives no token. The end_req byte leaves the lexer in its reset state.
module shell_command_tokenizer
  import sct_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] byte_req_i,
  input  logic       end_req_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [3:0] kind_o,
  output logic [7:0] char_out_o,
  output logic       last_o
);

  burst_t burst;
  tok_t   tok;
  logic   in_acc;

  // Advance the lexer state only on an accepted item.
  assign in_acc = in_valid_i && in_ready_o;

  sct_decode u_decode (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .acc_i   (in_acc),
    .byte_i  (byte_req_i),
    .fin_i   (end_req_i),
    .burst_o (burst)
  );

  sct_burst u_burst (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .burst_i     (burst),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .tok_o       (tok),
    .last_o      (last_o)
  );

  assign kind_o     = tok.kind;
  assign char_out_o = tok.ch;

endmodule

@@ rtl/sct_checker.sv @@
// Port-level checker for the shell command tokenizer and its bind.
`include "shell_command_tokenizer_macros.svh"

module sct_checker
  import sct_pkg::*;
(
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_ready_o,
  input logic       out_valid_o,
  input logic       out_ready_i,
  input logic [3:0] kind_o,
  input logic [7:0] char_out_o,
  input logic       last_o
);

  `SCT_ASSERT_NEXT(a_out_hold, out_valid_o && !out_ready_i, out_valid_o, "result dropped")
  `SCT_ASSERT_NOW(a_char_zero, out_valid_o && kind_o != K_CHAR, char_out_o == 8'd0, "stray char")
  `SCT_ASSERT_NOW(a_eol_last, out_valid_o && kind_o == K_EOL, last_o, "eol not last")
  `SCT_ASSERT_NOW(a_burst_busy, out_valid_o && !last_o, !in_ready_o, "taken mid burst")

endmodule

bind shell_command_tokenizer sct_checker u_sct_checker (.*);
